// ===== rtl/core/ppi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppi_pkg
// Shared widths, codes and divider interface types for the pitch period
// interpolator.
// ----------------------------------------------------------------------------
package ppi_pkg;

  // Field widths
  localparam int CMD_W      = 2;
  localparam int POS_W      = 24;
  localparam int PIDX_W     = 5;
  localparam int TIME_W     = 20;
  localparam int PITCH_W    = 14;
  localparam int PERIOD_W   = 16;
  localparam int SR_W       = 16;
  localparam int PTIME_W    = 20;
  localparam int CNT_CFG_W  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_L = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_R = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_LEN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_TIME   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_CNT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_CNT   = 3'd4;

  localparam logic [SR_W-1:0] SR_RESET = 16'd16000;

  // Time scale: samples -> 1/16 ms is pos * 16000 / sample_rate
  localparam int               TSCALE_W = 14;
  localparam logic [TSCALE_W-1:0] T_SCALE = 14'd16000;
  localparam int               TNUM_W   = POS_W + TSCALE_W;   // 38
  localparam int               OFF_W    = POS_W + 4;          // 16 * (len / kf)

  // floor(sr / 1000) as (sr * 67109) >> 26, exact for all 16-bit sr
  localparam int               KF_RECIP_W = 17;
  localparam logic [KF_RECIP_W-1:0] KF_RECIP = 17'd67109;
  localparam int               KF_SHIFT   = 26;
  localparam int               KF_W       = 7;

  // Serial divider sizes
  localparam int NUM_W  = 40;   // 16 * sample_rate * D
  localparam int DEN_W  = 35;   // p0*(D-x) + p1*x
  localparam int STEP_W = 6;
  localparam int PROD_W = PITCH_W + TIME_W;

  typedef struct packed {
    logic              go;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/core/ppi_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppi_div
// Restoring divider, one quotient bit per cycle. The dividend is loaded
// left-aligned so that steps bits of quotient are produced.
// ----------------------------------------------------------------------------
module ppi_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ppi_pkg::div_req_t req,
  output ppi_pkg::div_rsp_t rsp
);
  import ppi_pkg::*;

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0]  dvd_r, dvd_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;

  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    rem_dif;
  logic              ge;

  assign rem_sh  = {rem_r, dvd_r[NUM_W-1]};
  assign rem_dif = rem_sh - {1'b0, den_r};
  assign ge      = (rem_sh >= {1'b0, den_r});

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (req.go) begin
      run_nxt = 1'b1;
      cnt_nxt = req.steps;
      dvd_nxt = req.num;
      den_nxt = req.den;
      quo_nxt = '0;
      rem_nxt = '0;
    end else if (run_r) begin
      dvd_nxt = {dvd_r[NUM_W-2:0], 1'b0};
      rem_nxt = ge ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.go |-> !run_r)
    else $error("divider started while running");

  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(run_r))
    else $error("divider done without a run");

  a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r && !req.go && cnt_r == STEP_W'(1)) |=> (done_r && !run_r))
    else $error("divider missed its last step");

endmodule

// ===== rtl/core/pitch_period_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitch_period_interpolator
// Diphone pitch interpolation: two point tables, sample position in, pitch
// period in samples out, by linear interpolation between bracketing points.
// ----------------------------------------------------------------------------
// Load item: written in the accepting cycle, busy stays low, no result.
// Query item: two divides on the shared serial divider (one quotient bit per
//   cycle), a walk that reads one table entry per cycle, then a third divide
//   that is skipped when the pitch is zero. busy drops with the strobe, so a
//   new query is taken only once the last one has given its result.
// Reset (synchronous, rst_n low): control and config to reset values; the
//   point tables are not cleared. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module pitch_period_interpolator #(
  parameter int MAX_POINTS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Command channel
  input  logic                              start,
  output logic                              busy,
  input  logic [ppi_pkg::CMD_W-1:0]         in_command,
  input  logic [ppi_pkg::POS_W-1:0]         in_sample_position,
  input  logic [ppi_pkg::PIDX_W-1:0]        in_point_index,
  input  logic [ppi_pkg::TIME_W-1:0]        in_point_time,
  input  logic [ppi_pkg::PITCH_W-1:0]       in_point_pitch,
  // Result channel
  output logic                              out_valid,
  output logic [ppi_pkg::PERIOD_W-1:0]      out_pitch_period,
  output logic                              out_zero_pitch,
  // Configuration
  input  logic                              cfg_we,
  input  logic [ppi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppi_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ppi_pkg::*;

  // Table geometry. Both tables share one memory, table select in the MSB.
  localparam int IDX_W     = $clog2(MAX_POINTS);
  localparam int CNT_W     = $clog2(MAX_POINTS + 1);
  localparam int MEM_DEPTH = 2 ** (IDX_W + 1);
  localparam int ENTRY_W   = TIME_W + PITCH_W;
  localparam int IW        = (IDX_W > PIDX_W) ? IDX_W : PIDX_W;
  localparam int CW        = (CNT_W > CNT_CFG_W) ? CNT_W : CNT_CFG_W;
  localparam int PH_W      = TIME_W + 1;       // phone time, saturated at 2^20
  localparam int PHD_W     = TNUM_W + 2;       // signed phone time difference
  localparam int FD_W      = SR_W + TIME_W;

  localparam logic [PH_W-1:0] PH_SAT = PH_W'(1) << TIME_W;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PREP  = 9'b000000010,
    S_TDIV  = 9'b000000100,
    S_ODIV  = 9'b000001000,
    S_PHASE = 9'b000010000,
    S_WALK  = 9'b000100000,
    S_MUL   = 9'b001000000,
    S_SUM   = 9'b010000000,
    S_PDIV  = 9'b100000000
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [SR_W-1:0]      sample_rate_r;
  logic [POS_W-1:0]     left_len_r;
  logic [PTIME_W-1:0]   left_time_r;
  logic [CNT_CFG_W-1:0] left_cnt_r;
  logic [CNT_CFG_W-1:0] right_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_rate_r <= SR_RESET;
      left_len_r    <= '0;
      left_time_r   <= '0;
      left_cnt_r    <= '0;
      right_cnt_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_RATE: sample_rate_r <= cfg_data[SR_W-1:0];
        REG_LEFT_LEN:    left_len_r    <= cfg_data[POS_W-1:0];
        REG_LEFT_TIME:   left_time_r   <= cfg_data[PTIME_W-1:0];
        REG_LEFT_CNT:    left_cnt_r    <= cfg_data[CNT_CFG_W-1:0];
        REG_RIGHT_CNT:   right_cnt_r   <= cfg_data[CNT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Query state
  // --------------------------------------------------------------------------
  state_t               state_r, state_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [KF_W-1:0]      kf_r, kf_nxt;
  logic [TNUM_W-1:0]    t_r, t_nxt;
  logic [OFF_W-1:0]     off_r, off_nxt;
  logic                 tbl_r, tbl_nxt;
  logic [PH_W-1:0]      ph_r, ph_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     walk_idx_r, walk_idx_nxt;
  logic [TIME_W-1:0]    prev_time_r, prev_time_nxt;
  logic [PITCH_W-1:0]   prev_pitch_r, prev_pitch_nxt;
  logic                 interp_r, interp_nxt;
  logic [PITCH_W-1:0]   flat_pitch_r, flat_pitch_nxt;
  logic [PITCH_W-1:0]   p1_r, p1_nxt;
  logic [TIME_W-1:0]    d_r, d_nxt;
  logic [TIME_W-1:0]    dx_r, dx_nxt;
  logic [TIME_W-1:0]    x_r, x_nxt;
  logic [NUM_W-1:0]     num_r, num_nxt;
  logic [PROD_W-1:0]    prod_a_r, prod_a_nxt;
  logic [PROD_W-1:0]    prod_b_r, prod_b_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [PERIOD_W-1:0]  out_period_r, out_period_nxt;
  logic                 out_zero_r, out_zero_nxt;

  // Point memory
  logic [ENTRY_W-1:0]   pt_mem [MEM_DEPTH];
  logic [ENTRY_W-1:0]   rd_data_r;
  logic                 mem_we;
  logic [IDX_W:0]       wr_addr;
  logic                 rd_en;
  logic                 rd_tbl;
  logic [CNT_W-1:0]     rd_idx;
  logic [IDX_W:0]       rd_addr;

  div_req_t             div_req;
  div_rsp_t             div_rsp;

  // Helpers
  logic [SR_W-1:0]             f_val;        // sample rate, zero taken as one
  logic [SR_W+KF_RECIP_W-1:0]  kf_prod;
  logic [KF_W-1:0]             kf_raw;
  logic [TNUM_W-1:0]           tnum;
  logic                        in_left;
  logic                        left_tail;
  logic signed [PHD_W-1:0]     ph_diff;
  logic [CW-1:0]               cnt_raw;
  logic [CNT_W-1:0]            cnt_clamp;
  logic [IW:0]                 pidx_ext;
  logic                        slot_ok;
  logic [TIME_W-1:0]           rd_time;
  logic [PITCH_W-1:0]          rd_pitch;
  logic                        walk_pass;
  logic [CNT_W-1:0]            walk_inc;
  logic [FD_W-1:0]             fd_prod;
  logic [DEN_W-1:0]            den_sum;

  assign f_val    = (sample_rate_r == '0) ? SR_W'(1) : sample_rate_r;
  assign kf_prod  = sample_rate_r * KF_RECIP;
  assign kf_raw   = kf_prod[KF_SHIFT +: KF_W];
  assign tnum     = pos_r * T_SCALE;

  // Left part: phone time = t + left_phone_time - off; at or past the offset
  // the left tail pitch applies. Right part: t - off.
  assign in_left   = (pos_r < left_len_r);
  assign left_tail = in_left && (t_r >= TNUM_W'(off_r));
  assign ph_diff   = $signed({2'b00, t_r})
                   + $signed(PHD_W'(in_left ? left_time_r : '0))
                   - $signed(PHD_W'(off_r));

  // Point counts above the table depth clamp to it
  assign cnt_raw   = CW'(in_left ? left_cnt_r : right_cnt_r);
  assign cnt_clamp = (cnt_raw > CW'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                 : cnt_raw[CNT_W-1:0];

  assign pidx_ext  = (IW + 1)'(in_point_index);
  assign slot_ok   = (pidx_ext < (IW + 1)'(MAX_POINTS));

  assign rd_time   = rd_data_r[ENTRY_W-1:PITCH_W];
  assign rd_pitch  = rd_data_r[PITCH_W-1:0];
  assign walk_pass = (walk_idx_r < cnt_r) && (ph_r >= {1'b0, rd_time});
  assign walk_inc  = walk_idx_r + 1'b1;

  assign fd_prod   = f_val * d_r;
  assign den_sum   = {1'b0, prod_a_r} + {1'b0, prod_b_r};

  assign wr_addr   = {(in_command == CMD_LOAD_R), pidx_ext[IDX_W-1:0]};
  assign rd_addr   = {rd_tbl, rd_idx[IDX_W-1:0]};

  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    kf_nxt         = kf_r;
    t_nxt          = t_r;
    off_nxt        = off_r;
    tbl_nxt        = tbl_r;
    ph_nxt         = ph_r;
    cnt_nxt        = cnt_r;
    walk_idx_nxt   = walk_idx_r;
    prev_time_nxt  = prev_time_r;
    prev_pitch_nxt = prev_pitch_r;
    interp_nxt     = interp_r;
    flat_pitch_nxt = flat_pitch_r;
    p1_nxt         = p1_r;
    d_nxt          = d_r;
    dx_nxt         = dx_r;
    x_nxt          = x_r;
    num_nxt        = num_r;
    prod_a_nxt     = prod_a_r;
    prod_b_nxt     = prod_b_r;
    out_valid_nxt  = 1'b0;
    out_period_nxt = out_period_r;
    out_zero_nxt   = out_zero_r;
    div_req        = '0;
    mem_we         = 1'b0;
    rd_en          = 1'b0;
    rd_tbl         = tbl_r;
    rd_idx         = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_command == CMD_QUERY) begin
            pos_nxt   = in_sample_position;
            state_nxt = S_PREP;
          end else if ((in_command == CMD_LOAD_L || in_command == CMD_LOAD_R)
                       && slot_ok) begin
            mem_we = 1'b1;
          end
        end
      end

      // t = pos * 16000 / sample_rate
      S_PREP: begin
        div_req.go    = 1'b1;
        div_req.num   = {tnum, {(NUM_W - TNUM_W){1'b0}}};
        div_req.den   = DEN_W'(f_val);
        div_req.steps = STEP_W'(TNUM_W);
        kf_nxt        = (kf_raw == '0) ? KF_W'(1) : kf_raw;
        state_nxt     = S_TDIV;
      end

      // off = 16 * (left_length / kf), whole milliseconds
      S_TDIV: begin
        if (div_rsp.done) begin
          t_nxt         = div_rsp.quot[TNUM_W-1:0];
          div_req.go    = 1'b1;
          div_req.num   = {left_len_r, {(NUM_W - POS_W){1'b0}}};
          div_req.den   = DEN_W'(kf_r);
          div_req.steps = STEP_W'(POS_W);
          state_nxt     = S_ODIV;
        end
      end

      S_ODIV: begin
        if (div_rsp.done) begin
          off_nxt   = {div_rsp.quot[POS_W-1:0], 4'b0000};
          state_nxt = S_PHASE;
        end
      end

      // Phone time, clamped at zero and saturated past the 20-bit range.
      // The left tail case saturates too, so the walk ends on the last point.
      S_PHASE: begin
        if (left_tail) begin
          ph_nxt = PH_SAT;
        end else if (ph_diff < 0) begin
          ph_nxt = '0;
        end else if (ph_diff >= $signed(PHD_W'(PH_SAT))) begin
          ph_nxt = PH_SAT;
        end else begin
          ph_nxt = ph_diff[PH_W-1:0];
        end
        tbl_nxt      = !in_left;
        cnt_nxt      = cnt_clamp;
        walk_idx_nxt = '0;
        rd_en        = 1'b1;
        rd_tbl       = !in_left;
        rd_idx       = '0;
        state_nxt    = S_WALK;
      end

      // One point per cycle: data of walk_idx arrives, next read goes out
      S_WALK: begin
        if (walk_pass) begin
          prev_time_nxt  = rd_time;
          prev_pitch_nxt = rd_pitch;
          walk_idx_nxt   = walk_inc;
          rd_en          = 1'b1;
          rd_idx         = walk_inc;
        end else begin
          state_nxt = S_MUL;
          if (walk_idx_r >= cnt_r) begin
            // past the last point: tail pitch, zero for an empty table
            interp_nxt     = 1'b0;
            flat_pitch_nxt = (cnt_r == '0) ? '0 : prev_pitch_r;
          end else if (walk_idx_r == '0) begin
            // before the first point
            interp_nxt     = 1'b0;
            flat_pitch_nxt = rd_pitch;
          end else begin
            interp_nxt = 1'b1;
            p1_nxt     = rd_pitch;
            d_nxt      = rd_time - prev_time_r;
            dx_nxt     = rd_time - ph_r[TIME_W-1:0];
            x_nxt      = ph_r[TIME_W-1:0] - prev_time_r;
          end
        end
      end

      // Interpolated: period = 16*f*D / (p0*(D-x) + p1*x)
      S_MUL: begin
        if (interp_r) begin
          num_nxt    = {fd_prod, 4'b0000};
          prod_a_nxt = prev_pitch_r * dx_r;
          prod_b_nxt = p1_r * x_r;
        end else begin
          num_nxt    = NUM_W'({f_val, 4'b0000});
          prod_a_nxt = PROD_W'(flat_pitch_r);
          prod_b_nxt = '0;
        end
        state_nxt = S_SUM;
      end

      S_SUM: begin
        if (den_sum == '0) begin
          out_valid_nxt  = 1'b1;
          out_period_nxt = '1;
          out_zero_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          div_req.go    = 1'b1;
          div_req.num   = num_r;
          div_req.den   = den_sum;
          div_req.steps = STEP_W'(NUM_W);
          state_nxt     = S_PDIV;
        end
      end

      S_PDIV: begin
        if (div_rsp.done) begin
          out_valid_nxt  = 1'b1;
          out_period_nxt = (|div_rsp.quot[NUM_W-1:PERIOD_W]) ? '1
                                                             : div_rsp.quot[PERIOD_W-1:0];
          out_zero_nxt   = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      walk_idx_r  <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      walk_idx_r  <= walk_idx_nxt;
      cnt_r       <= cnt_nxt;
    end
    pos_r        <= pos_nxt;
    kf_r         <= kf_nxt;
    t_r          <= t_nxt;
    off_r        <= off_nxt;
    tbl_r        <= tbl_nxt;
    ph_r         <= ph_nxt;
    prev_time_r  <= prev_time_nxt;
    prev_pitch_r <= prev_pitch_nxt;
    interp_r     <= interp_nxt;
    flat_pitch_r <= flat_pitch_nxt;
    p1_r         <= p1_nxt;
    d_r          <= d_nxt;
    dx_r         <= dx_nxt;
    x_r          <= x_nxt;
    num_r        <= num_nxt;
    prod_a_r     <= prod_a_nxt;
    prod_b_r     <= prod_b_nxt;
    out_period_r <= out_period_nxt;
    out_zero_r   <= out_zero_nxt;
  end

  // Loads only land in IDLE and reads only happen mid-query, so a write and
  // a read never meet on one entry.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pt_mem[wr_addr] <= {in_point_time, in_point_pitch};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= pt_mem[rd_addr];
    end
  end

  ppi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_pitch_period = out_period_r;
  assign out_zero_pitch   = out_zero_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while a query is still running");

  a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command != CMD_QUERY) |=> (state_r == S_IDLE))
    else $error("load item left the block busy");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (walk_idx_r <= cnt_r))
    else $error("walk index past point count");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_TDIV || state_r == S_ODIV || state_r == S_PDIV))
    else $error("divider finished outside a divide state");

endmodule
